FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the bit slicer.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ZCBS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ZCBS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: src/zcbs_pkg.sv
// Constants and types for the zero-crossing bit slicer.
// No dependencies; imported by zero_crossing_bit_slicer and tb_top.
package zcbs_pkg;

    localparam int WORD_BITS   = 63;
    localparam int SAMPLE_BITS = 16;
    localparam int REG_BITS    = 16;
    localparam int PHASE_BITS  = 18;
    localparam int COUNT_BITS  = 6;
    localparam int DCD_BITS    = 17;
    localparam int PAT_BITS    = 24;
    localparam int IDX_BITS    = 2;

    localparam logic [IDX_BITS-1:0] REG_CLOCK_STEP = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_PULL_GAIN  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_DCD_LOAD   = 2'd2;

    localparam logic [REG_BITS-1:0] CLOCK_STEP_RST = 16'd8192;
    localparam logic [REG_BITS-1:0] PULL_GAIN_RST  = 16'd49152;
    localparam logic [REG_BITS-1:0] DCD_LOAD_RST   = 16'd480;

    localparam logic signed [PHASE_BITS-1:0] HALF_SYMBOL = 18'sd32768;
    localparam logic signed [PHASE_BITS-1:0] ONE_SYMBOL  = 18'sd65536;

    localparam logic [PAT_BITS-1:0] PAT_A = 24'h808080;
    localparam logic [PAT_BITS-1:0] PAT_B = 24'h7F7F7F;
    localparam logic [PAT_BITS-1:0] PAT_C = 24'h555555;

    localparam logic [COUNT_BITS-1:0] WORD_LAST = COUNT_BITS'(WORD_BITS);
    localparam logic signed [DCD_BITS-1:0] DCD_NONE = '1;

    typedef struct packed {
        logic [REG_BITS-1:0] clock_step;
        logic [REG_BITS-1:0] pull_gain;
        logic [REG_BITS-1:0] dcd_load;
    } t_cfg;

endpackage

FILE: src/zero_crossing_bit_slicer.sv
// Zero-crossing bit slicer with symbol clock recovery, top level.
// Depends on zcbs_pkg and assert_macros.svh.
//
// Usage:
//   Input channel i_valid/o_ready carries one signed sample per request.
//   Output channel o_valid/i_ready returns one result per sample: a
//   word_valid flag, the completed 63-bit data word (zero when no word
//   completes) and the carrier-detect countdown after that sample.
//   Registers are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
//   writes them only while the block is idle (the block does not enforce
//   this): 0 clock_step, 1 pull_gain, 2 dcd_load; index 3 is ignored.
//   A sample is held in the input register on acceptance and its result
//   in the result register when it advances; throughput is one sample per
//   cycle while the receiver does not stall, set by the combinational phase update (add, threshold, 18x16 scale).
//   A stalled receiver holds the result register; the input register
//   still takes one more sample, after which o_ready drops until the
//   result is taken.
//   Synchronous reset restores the register defaults and clears phase,
//   shift word, bit count, carrier count and the previous sample.
`include "assert_macros.svh"

module zero_crossing_bit_slicer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [zcbs_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_word_valid,
    output logic [zcbs_pkg::WORD_BITS-1:0]        o_data_word,
    output logic signed [zcbs_pkg::DCD_BITS-1:0]  o_dcd_count,
    input  logic                                  i_cfg_we,
    input  logic [zcbs_pkg::IDX_BITS-1:0]         i_cfg_index,
    input  logic [zcbs_pkg::REG_BITS-1:0]         i_cfg_data
);
    import zcbs_pkg::*;

    t_cfg                         r_cfg;
    logic                         r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                         r_out_valid;
    logic                         r_word_valid;
    logic [WORD_BITS-1:0]         r_data_word;

    logic signed [PHASE_BITS-1:0] r_phase;
    logic [WORD_BITS-1:0]         r_shift;
    logic [COUNT_BITS-1:0]        r_count;
    logic signed [DCD_BITS-1:0]   r_carrier;
    logic                         r_prev_pos;

    logic                         adv;
    logic                         s_pos;
    logic                         bit_tick;
    logic                         word_done;
    logic signed [PHASE_BITS-1:0] p_add;
    logic signed [PHASE_BITS-1:0] p_bit;
    logic [PHASE_BITS-1:0]        p_mag;
    logic [PHASE_BITS+REG_BITS-1:0] p_prod;
    logic [PHASE_BITS-1:0]        p_scaled;
    logic [COUNT_BITS-1:0]        cnt_inc;
    logic [WORD_BITS-1:0]         shift_in;
    logic [PAT_BITS-1:0]          pat;
    logic signed [DCD_BITS-1:0]   car_dec;

    logic signed [PHASE_BITS-1:0] n_phase;
    logic [WORD_BITS-1:0]         n_shift;
    logic [COUNT_BITS-1:0]        n_count;
    logic signed [DCD_BITS-1:0]   n_carrier;
    logic [WORD_BITS-1:0]         n_data_word;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_comb begin
        s_pos     = !r_in_sample[SAMPLE_BITS-1] && (|r_in_sample);
        p_add     = r_phase + $signed({{(PHASE_BITS-REG_BITS){1'b0}}, r_cfg.clock_step});
        bit_tick  = p_add > HALF_SYMBOL;
        p_bit     = bit_tick ? p_add - ONE_SYMBOL : p_add;
        p_mag     = p_bit[PHASE_BITS-1] ? PHASE_BITS'(-p_bit) : PHASE_BITS'(p_bit);
        p_prod    = p_mag * r_cfg.pull_gain;
        p_scaled  = p_prod[PHASE_BITS+REG_BITS-1:REG_BITS];
        n_phase   = p_bit;
        if (r_prev_pos ^ s_pos) begin
            n_phase = p_bit[PHASE_BITS-1] ? $signed(PHASE_BITS'(-p_scaled))
                                          : $signed(p_scaled);
        end

        shift_in    = {r_shift[WORD_BITS-2:0], s_pos};
        cnt_inc     = r_count + COUNT_BITS'(1);
        word_done   = bit_tick && (cnt_inc >= WORD_LAST);
        car_dec     = (r_carrier == DCD_NONE) ? DCD_NONE : r_carrier - DCD_BITS'(1);
        n_shift     = r_shift;
        n_count     = r_count;
        n_carrier   = r_carrier;
        n_data_word = '0;
        if (bit_tick) begin
            n_shift   = word_done ? '0 : shift_in;
            n_count   = word_done ? '0 : cnt_inc;
            n_carrier = car_dec;
        end
        if (word_done) begin
            n_data_word = shift_in;
        end
        pat = n_shift[PAT_BITS-1:0];
        if (bit_tick && (pat == PAT_A || pat == PAT_B || pat == PAT_C)) begin
            n_carrier = $signed({1'b0, r_cfg.dcd_load});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_step <= CLOCK_STEP_RST;
            r_cfg.pull_gain  <= PULL_GAIN_RST;
            r_cfg.dcd_load   <= DCD_LOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLOCK_STEP: r_cfg.clock_step <= i_cfg_data;
                REG_PULL_GAIN:  r_cfg.pull_gain  <= i_cfg_data;
                REG_DCD_LOAD:   r_cfg.dcd_load   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_shift     <= '0;
            r_count     <= '0;
            r_carrier   <= '0;
            r_prev_pos  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_count     <= n_count;
                r_carrier   <= n_carrier;
                r_prev_pos  <= s_pos;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_sample <= i_sample;
        end
        if (adv) begin
            r_word_valid <= word_done;
            r_data_word  <= n_data_word;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_word_valid = r_word_valid;
    assign o_data_word  = r_data_word;
    assign o_dcd_count  = r_carrier;

    `ZCBS_ASSERT(a_count_range, r_count < WORD_LAST, "bit count reached word length")
    `ZCBS_ASSERT(a_carrier_floor, r_carrier >= DCD_NONE, "carrier count below floor")
    `ZCBS_ASSERT(a_empty_word, !(o_valid && !o_word_valid) || (o_data_word == '0),
        "data word nonzero without word_valid")
    `ZCBS_ASSERT_NEXT(a_in_hold, r_in_valid && r_out_valid && !i_ready,
        r_in_valid && $stable(r_in_sample), "input register lost a request on stall")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for zero_crossing_bit_slicer: drives sample requests,
// predicts the sliced words and carrier countdown, and checks every result.
// Depends on zcbs_pkg and the RTL of the block only.
module tb_top;
    import zcbs_pkg::*;

    localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                       word_valid;
        logic [WORD_BITS-1:0]       data_word;
        logic signed [DCD_BITS-1:0] dcd_count;
    } t_slice;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_word_valid;
    logic [WORD_BITS-1:0]          o_data_word;
    logic signed [DCD_BITS-1:0]    o_dcd_count;
    logic                          i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0]           i_cfg_index = '0;
    logic [REG_BITS-1:0]           i_cfg_data = '0;

    zero_crossing_bit_slicer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_valid (o_word_valid),
        .o_data_word  (o_data_word),
        .o_dcd_count  (o_dcd_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // predictor state
    t_cfg                 cfg = '{clock_step: CLOCK_STEP_RST, pull_gain: PULL_GAIN_RST,
                                  dcd_load: DCD_LOAD_RST};
    int                   phase_q16 = 0;
    logic [WORD_BITS-1:0] shift_word = '0;
    int                   bits_held = 0;
    int                   carrier_left = 0;
    int                   last_sample = 0;

    t_slice expected_slices[$];
    int     error_count = 0;
    int     sent_count = 0;
    bit     idle_en = 1'b1;
    int     stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_slice slice_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        int                  s;
        t_slice              r;
        logic [PAT_BITS-1:0] pat;
        longint              mag;
        s = smp;
        r = '0;
        phase_q16 += int'(cfg.clock_step);
        if (phase_q16 > HALF_SYMBOL) begin
            phase_q16 -= ONE_SYMBOL;
            shift_word = {shift_word[WORD_BITS-2:0], s > 0};
            bits_held = (bits_held + 1) % 64;
            if (bits_held >= WORD_BITS) begin
                bits_held = 0;
                r.word_valid = 1'b1;
                r.data_word = shift_word;
                shift_word = '0;
            end
            carrier_left -= 1;
            if (carrier_left < -1) begin
                carrier_left = -1;
            end
            pat = shift_word[PAT_BITS-1:0];
            if (pat == PAT_A || pat == PAT_B || pat == PAT_C) begin
                carrier_left = int'(cfg.dcd_load);
            end
        end
        // pull the bit clock on a zero crossing
        if ((last_sample > 0) ? (s <= 0) : (s > 0)) begin
            mag = (phase_q16 < 0) ? -longint'(phase_q16) : longint'(phase_q16);
            mag = (mag * longint'(cfg.pull_gain)) >>> 16;
            phase_q16 = (phase_q16 < 0) ? -int'(mag) : int'(mag);
        end
        last_sample = s;
        r.dcd_count = DCD_BITS'(carrier_left);
        return r;
    endfunction

    function automatic int symbol_span(input logic [REG_BITS-1:0] cs);
        int n;
        if (cs == 0) begin
            return 8;
        end
        n = (65536 + int'(cs) / 2) / int'(cs);
        return (n > 24) ? 24 : ((n < 1) ? 1 : n);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= v;
        expected_slices.push_back(slice_sample(v));
        sent_count++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic end_phase();
        i_valid <= 1'b0;
        while (expected_slices.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [REG_BITS-1:0] cs, input logic [REG_BITS-1:0] pg,
                             input logic [REG_BITS-1:0] dl, input bit poke_spare);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_CLOCK_STEP;
        i_cfg_data <= cs;
        @(posedge i_clk);
        i_cfg_index <= REG_PULL_GAIN;
        i_cfg_data <= pg;
        @(posedge i_clk);
        i_cfg_index <= REG_DCD_LOAD;
        i_cfg_data <= dl;
        @(posedge i_clk);
        if (poke_spare) begin
            i_cfg_index <= REG_SPARE;
            i_cfg_data <= REG_BITS'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg = '{clock_step: cs, pull_gain: pg, dcd_load: dl};
    endtask

    // preamble bytes, then data bytes, one bit held for span samples;
    // some bits flipped and some noise runs in between
    task automatic send_frames(input int n_items, input int span);
        int         first;
        int         pre_bytes;
        int         n_bytes;
        logic [7:0] pre;
        logic [7:0] byte_val;
        bit         b;
        first = sent_count;
        while (sent_count - first < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 20)) begin
                    if (sent_count - first < n_items) begin
                        send_sample(SAMPLE_BITS'($urandom));
                    end
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        pre = PAT_A[7:0];
                    end
                    1: begin
                        pre = PAT_B[7:0];
                    end
                    default: begin
                        pre = PAT_C[7:0];
                    end
                endcase
                pre_bytes = $urandom_range(2, 5);
                n_bytes = pre_bytes + $urandom_range(1, 8);
                for (int k = 0; k < n_bytes; k++) begin
                    byte_val = (k < pre_bytes) ? pre : 8'($urandom);
                    for (int j = 7; j >= 0; j--) begin
                        b = byte_val[j];
                        if ($urandom_range(0, 31) == 0) begin
                            b = !b;
                        end
                        for (int m = 0; m < span && sent_count - first < n_items; m++) begin
                            send_sample(b ? SAMPLE_BITS'($urandom_range(1, 32767))
                                          : SAMPLE_BITS'(-int'($urandom_range(0, 32768))));
                        end
                    end
                end
            end
        end
    endtask

    task automatic test_sample_extremes();
        logic signed [SAMPLE_BITS-1:0] corner [12] = '{
            16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1, 16'sd0,
            -16'sd32768, 16'sd32767, 16'sd1, 16'sd1, 16'sd0, -16'sd1};
        foreach (corner[k]) begin
            send_sample(corner[k]);
        end
        end_phase();
    endtask

    task automatic test_rate_extremes();
        load_regs(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
        for (int k = 0; k < 6; k++) begin
            send_sample((k % 2) ? -16'sd32768 : 16'sd32767);
        end
        end_phase();
        load_regs(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        for (int k = 0; k < 6; k++) begin
            send_sample((k % 3) ? 16'sd1 : 16'sd0);
        end
        end_phase();
    endtask

    task automatic test_preamble_frames();
        load_regs(16'hFFFF, 16'h8000, 16'hFFFF, 1'b0);
        send_frames(250, 1);
        end_phase();
        load_regs(16'd32768, 16'hFFFF, REG_BITS'($urandom_range(0, 40)), 1'b1);
        send_frames(150, symbol_span(16'd32768));
        end_phase();
    endtask

    task automatic test_symbol_rates();
        logic [REG_BITS-1:0] cs;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    cs = 16'd16384;
                    load_regs(cs, REG_BITS'($urandom), REG_BITS'($urandom_range(0, 100)), 1'b0);
                end
                1: begin
                    cs = 16'd21845;
                    load_regs(cs, 16'hFFFF, 16'h0000, 1'b1);
                end
                2: begin
                    cs = 16'd8192;
                    load_regs(cs, 16'h0000, REG_BITS'($urandom), 1'b0);
                end
                default: begin
                    cs = REG_BITS'($urandom_range(6000, 60000));
                    load_regs(cs, REG_BITS'($urandom), REG_BITS'($urandom), 1'b1);
                end
            endcase
            send_frames(150, symbol_span(cs));
            end_phase();
        end
    endtask

    task automatic test_noise();
        load_regs(REG_BITS'($urandom), 16'hFFFF, 16'hFFFF, 1'b1);
        repeat (150) send_sample(SAMPLE_BITS'($urandom));
        end_phase();
        load_regs(16'h0000, REG_BITS'($urandom), REG_BITS'($urandom), 1'b0);
        repeat (80) send_sample(SAMPLE_BITS'($urandom));
        end_phase();
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        load_regs(16'hFFFF, PULL_GAIN_RST, DCD_LOAD_RST, 1'b0);
        send_frames(320, 1);
        end_phase();
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= (stall_left == 1);
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_slice want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_slices.size() == 0) begin
                error_count++;
                $display("%0t: result with no request pending: word_valid %0b data %h dcd %0d",
                         $time, o_word_valid, o_data_word, o_dcd_count);
            end else begin
                want = expected_slices.pop_front();
                if (o_word_valid !== want.word_valid) begin
                    error_count++;
                    $display("%0t: word_valid expected %0b actual %0b",
                             $time, want.word_valid, o_word_valid);
                end
                if (o_data_word !== want.data_word) begin
                    error_count++;
                    $display("%0t: data_word expected %h actual %h",
                             $time, want.data_word, o_data_word);
                end
                if (o_dcd_count !== want.dcd_count) begin
                    error_count++;
                    $display("%0t: dcd_count expected %0d actual %0d",
                             $time, want.dcd_count, o_dcd_count);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sample_extremes();
        test_rate_extremes();
        test_preamble_frames();
        test_symbol_rates();
        test_noise();
        test_full_rate();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_slices.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/zcbs_pkg.sv
src/zero_crossing_bit_slicer.sv
tb/tb_top.sv
